[hdl/idq_pkg.sv]
`default_nettype none

package idq_pkg;

    // operation codes
    localparam logic [2:0] OP_PUSH_TOP   = 3'd0;
    localparam logic [2:0] OP_PUSH_BOT   = 3'd1;
    localparam logic [2:0] OP_POP_TOP    = 3'd2;
    localparam logic [2:0] OP_POP_BOT    = 3'd3;
    localparam logic [2:0] OP_REMOVE_IDX = 3'd4;
    localparam logic [2:0] OP_READ_IDX   = 3'd5;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_INVALID   = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } state_t;

    // one request
    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
        logic [5:0]  position;
    } request_t;

    // one result
    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [6:0]  count;
    } result_t;

endpackage

`default_nettype wire

[hdl/indexed_deque.sv]
`default_nettype none

// Bounded double-ended queue of up to DEPTH words held in one single-port-read,
// single-port-write synchronous RAM. A request is taken when start is high and
// busy is low; its result appears on result for exactly one cycle with done
// high, and must be captured then since the block cannot be stalled. Push,
// pop and any rejected request give their result in the cycle after start.
// Read at an index passes through ST_READ for the registered RAM read.
// Remove at index p with n stored words moves each later word up one slot
// through the RAM, one read and one write per word.
// busy is high only for read and remove, from the cycle after start until done.
module indexed_deque #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic start,
    input  wire idq_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output idq_pkg::result_t   result
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam int SW   = AW + 2;

    // word storage
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] mem_q;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;

    idq_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    idq_pkg::result_t  res_reg, res_next;
    logic              done_reg, done_next;

    logic              full;
    logic              empty;
    logic              pos_ok;
    logic [AW-1:0]     head_dec;
    logic [CW-1:0]     idx_inc;

    // slot of the word at a given offset from the top
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(offset);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pos_ok   = (CMPW'(request.position) < CMPW'(count_reg));
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign idx_inc  = idx_reg + CW'(1);

    // ram: registered read, plain write
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idq_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    // sequencer: next state, ram accesses and result
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = slot_of(head_reg, idx_reg);
        mem_wdata  = DATA_WIDTH'(request.value);
        mem_re     = 1'b0;
        mem_raddr  = slot_of(head_reg, CW'(request.position));

        unique case (state_reg)
            idq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    res_next.read_value = '0;
                    res_next.status     = idq_pkg::STATUS_OK;
                    unique case (request.operation)
                        idq_pkg::OP_PUSH_TOP:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                res_next.status = idq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                head_next  = head_dec;
                                mem_we     = 1'b1;
                                mem_waddr  = head_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        idq_pkg::OP_PUSH_BOT:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                res_next.status = idq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = slot_of(head_reg, count_reg);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        idq_pkg::OP_POP_TOP:
                        begin
                            done_next = 1'b1;
                            if (empty)
                            begin
                                res_next.status = idq_pkg::STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                head_next  = slot_of(head_reg, CW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        idq_pkg::OP_POP_BOT:
                        begin
                            done_next = 1'b1;
                            if (empty)
                            begin
                                res_next.status = idq_pkg::STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        idq_pkg::OP_REMOVE_IDX:
                        begin
                            if (!pos_ok)
                            begin
                                done_next       = 1'b1;
                                res_next.status = idq_pkg::STATUS_INVALID;
                            end
                            else
                            begin
                                idx_next   = CW'(request.position);
                                state_next = idq_pkg::ST_SHIFT_RD;
                            end
                        end
                        idq_pkg::OP_READ_IDX:
                        begin
                            if (!pos_ok)
                            begin
                                done_next       = 1'b1;
                                res_next.status = idq_pkg::STATUS_INVALID;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = idq_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            done_next       = 1'b1;
                            res_next.status = idq_pkg::STATUS_INVALID;
                        end
                    endcase
                end
            end
            // read data back from the ram
            idq_pkg::ST_READ:
            begin
                res_next.read_value = 32'(mem_q);
                done_next           = 1'b1;
                state_next          = idq_pkg::ST_IDLE;
            end
            // fetch the next word below the gap, or finish
            idq_pkg::ST_SHIFT_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = slot_of(head_reg, idx_inc);
                    state_next = idq_pkg::ST_SHIFT_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = idq_pkg::ST_IDLE;
                end
            end
            // move it up one slot
            idq_pkg::ST_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_q;
                idx_next   = idx_inc;
                state_next = idq_pkg::ST_SHIFT_RD;
            end
            default:
            begin
                state_next = idq_pkg::ST_IDLE;
            end
        endcase

        if (done_next)
        begin
            res_next.count = 7'(count_next);
        end
    end

    assign busy   = (state_reg != idq_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[tb/deque_checker.sv]
`timescale 1ns / 1ps

module deque_checker
    import idq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  request_t  request,
    input  wire logic done,
    input  result_t   result,
    output int        failures,
    output int        pending
);

    localparam int WORDS = 64;

    // shadow copy of the deque contents
    logic [31:0] deque_words [WORDS];
    logic [5:0]  top_slot;
    logic [6:0]  word_count;

    result_t expected_results [$];
    result_t want;

    // apply one request to the shadow deque and return its result
    function automatic result_t apply_request(input request_t r);
        result_t    res;
        logic [5:0] slot;
        res = '0;
        res.status = STATUS_OK;
        case (r.operation)
            OP_PUSH_TOP:
                if (int'(word_count) >= WORDS)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    top_slot = top_slot - 6'd1;
                    deque_words[top_slot] = r.value;
                    word_count = word_count + 7'd1;
                end
            OP_PUSH_BOT:
                if (int'(word_count) >= WORDS)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    slot = top_slot + word_count[5:0];
                    deque_words[slot] = r.value;
                    word_count = word_count + 7'd1;
                end
            OP_POP_TOP:
                if (word_count == 7'd0)
                begin
                    res.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    top_slot = top_slot + 6'd1;
                    word_count = word_count - 7'd1;
                end
            OP_POP_BOT:
                if (word_count == 7'd0)
                begin
                    res.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    word_count = word_count - 7'd1;
                end
            OP_REMOVE_IDX:
                if ({1'b0, r.position} >= word_count)
                begin
                    res.status = STATUS_INVALID;
                end
                else
                begin
                    // later words move up one place to close the gap
                    for (int i = r.position; i + 1 < int'(word_count); i++)
                    begin
                        slot = top_slot + 6'(i);
                        deque_words[slot] = deque_words[slot + 6'd1];
                    end
                    word_count = word_count - 7'd1;
                end
            OP_READ_IDX:
                if ({1'b0, r.position} >= word_count)
                begin
                    res.status = STATUS_INVALID;
                end
                else
                begin
                    slot = top_slot + r.position;
                    res.read_value = deque_words[slot];
                end
            default:
                res.status = STATUS_INVALID;
        endcase
        res.count = word_count;
        return res;
    endfunction

    // report one field that differs
    function automatic void report_field(input string field, input logic [31:0] exp_val,
                                         input logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val,
                     got_val);
            failures++;
        end
    endfunction

    initial
    begin
        failures = 0;
        pending = 0;
        top_slot = '0;
        word_count = '0;
    end

    // compare results as they leave, predict requests as they are taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_slot = '0;
            word_count = '0;
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             result);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("read_value", want.read_value, result.read_value);
                    report_field("status", 32'(want.status), 32'(result.status));
                    report_field("count", 32'(want.count), 32'(result.count));
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(apply_request(request));
            end
        end
        pending = expected_results.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import idq_pkg::*;

    localparam int          WORDS         = 64;
    localparam int          RANDOM_ITEMS  = 1250;
    localparam int          QUIET_TAIL    = 150;
    localparam int          DRAIN_CYCLES  = 2 * WORDS + 8;
    localparam logic [2:0]  OP_SPARE_LO   = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI   = 3'd7;

    typedef enum int {
        PHASE_GROW,
        PHASE_SHRINK,
        PHASE_MIXED,
        PHASE_NOISE
    } phase_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;
    int       failures;
    int       pending;

    // occupancy as seen from the request side, used to aim positions
    int level;
    int issued;
    int idle_cutoff;

    indexed_deque i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    deque_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .failures (failures),
        .pending  (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // keep the occupancy estimate in step with each request sent
    function automatic void track_level(input request_t r);
        case (r.operation)
            OP_PUSH_TOP, OP_PUSH_BOT:
                if (level < WORDS) level++;
            OP_POP_TOP, OP_POP_BOT:
                if (level > 0) level--;
            OP_REMOVE_IDX:
                if (int'(r.position) < level) level--;
            default:
                ;
        endcase
    endfunction

    // drive one request and hold it until the block takes it
    task automatic send_request(input request_t r);
        int gap;
        if (issued < idle_cutoff && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        issued++;
        track_level(r);
    endtask

    task automatic issue(input logic [2:0] op, input logic [31:0] word,
                         input logic [5:0] pos);
        request_t r;
        r.operation = op;
        r.value = word;
        r.position = pos;
        send_request(r);
    endtask

    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 32'h0;
        if (roll == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // mostly valid positions, some at the boundary, some anywhere
    function automatic logic [5:0] pick_position();
        int roll;
        roll = $urandom_range(0, 15);
        if (level == 0 || roll == 0) return 6'($urandom_range(0, WORDS - 1));
        if (roll == 1 && level < WORDS) return 6'(level);
        return 6'($urandom_range(0, level - 1));
    endfunction

    function automatic request_t pick_request(input phase_t ph);
        request_t r;
        int       roll;
        r.value = pick_word();
        r.position = pick_position();
        roll = $urandom_range(0, 99);
        case (ph)
            PHASE_GROW:
                if (roll < 80)      r.operation = roll[0] ? OP_PUSH_TOP : OP_PUSH_BOT;
                else if (roll < 90) r.operation = OP_READ_IDX;
                else if (roll < 95) r.operation = OP_REMOVE_IDX;
                else                r.operation = roll[0] ? OP_POP_TOP : OP_POP_BOT;
            PHASE_SHRINK:
                if (roll < 25)      r.operation = OP_POP_TOP;
                else if (roll < 50) r.operation = OP_POP_BOT;
                else if (roll < 75) r.operation = OP_REMOVE_IDX;
                else if (roll < 90) r.operation = OP_READ_IDX;
                else                r.operation = roll[0] ? OP_PUSH_TOP : OP_PUSH_BOT;
            PHASE_MIXED:
                r.operation = 3'($urandom_range(0, 5));
            default:
            begin
                r.operation = 3'($urandom_range(0, 7));
                r.position = 6'($urandom_range(0, WORDS - 1));
            end
        endcase
        return r;
    endfunction

    // run items until the deque sits at the target level for a few requests
    task automatic run_to_edge(input phase_t ph, input int target);
        int extra;
        extra = $urandom_range(1, 3);
        while (extra > 0)
        begin
            if (level == target) extra--;
            send_request(pick_request(ph));
        end
    endtask

    task automatic run_span(input phase_t ph, input int length);
        repeat (length) send_request(pick_request(ph));
    endtask

    // stimulus and verdict
    initial
    begin
        int roll;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        level = 0;
        issued = 0;
        idle_cutoff = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // empty deque corner cases
        issue(OP_POP_TOP, 32'h0, 6'd0);
        issue(OP_POP_BOT, 32'h0, 6'd0);
        issue(OP_REMOVE_IDX, 32'h0, 6'd0);
        issue(OP_READ_IDX, 32'hFFFF_FFFF, 6'd63);
        issue(OP_SPARE_LO, 32'hFFFF_FFFF, 6'd63);
        issue(OP_SPARE_HI, 32'h0, 6'd0);

        // last element removed from either end
        issue(OP_PUSH_TOP, 32'hFFFF_FFFF, 6'd63);
        issue(OP_POP_BOT, 32'h0, 6'd0);
        issue(OP_PUSH_BOT, 32'h0, 6'd63);
        issue(OP_POP_TOP, 32'h0, 6'd0);

        // a few words, then reads and removes at the edges of the index range
        issue(OP_PUSH_TOP, 32'h1111_1111, 6'd0);
        issue(OP_PUSH_BOT, 32'h2222_2222, 6'd0);
        issue(OP_PUSH_TOP, 32'h3333_3333, 6'd0);
        issue(OP_READ_IDX, 32'h0, 6'd0);
        issue(OP_READ_IDX, 32'h0, 6'd2);
        issue(OP_READ_IDX, 32'h0, 6'd3);
        issue(OP_REMOVE_IDX, 32'h0, 6'd1);
        issue(OP_REMOVE_IDX, 32'h0, 6'd63);
        issue(OP_READ_IDX, 32'h0, 6'd1);
        issue(OP_REMOVE_IDX, 32'h0, 6'd1);
        issue(OP_REMOVE_IDX, 32'h0, 6'd0);
        issue(OP_READ_IDX, 32'h0, 6'd0);

        // random phases, first one filling the deque past full
        idle_cutoff = issued + RANDOM_ITEMS - QUIET_TAIL;
        run_to_edge(PHASE_GROW, WORDS);
        while (issued < idle_cutoff + QUIET_TAIL)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 3)      run_to_edge(PHASE_GROW, WORDS);
            else if (roll < 6) run_to_edge(PHASE_SHRINK, 0);
            else if (roll < 9) run_span(PHASE_MIXED, $urandom_range(20, 60));
            else               run_span(PHASE_NOISE, $urandom_range(5, 10));
        end

        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
hdl/idq_pkg.sv
hdl/indexed_deque.sv
tb/deque_checker.sv
tb/testbench.sv
